/* rtl/esr_pkg.sv */
// Shared types and constants for the elevation spike remover.
`default_nettype none

package esr_pkg;

  localparam int ELEV_W   = 16;
  localparam int TW_W     = 13;
  localparam int TH_W     = 16;
  localparam int THR_W    = 16;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [TW_W-1:0]   TILE_WIDTH_RST  = 13'd1201;
  localparam logic [TH_W-1:0]   TILE_HEIGHT_RST = 16'd1201;
  localparam logic [ELEV_W-1:0] NODATA_RST      = 16'h8000;
  localparam logic [THR_W-1:0]  THRESHOLD_RST   = 16'd1000;

  // request codes on the input channel
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_TILE_WIDTH  = 2'd0,
    REG_TILE_HEIGHT = 2'd1,
    REG_NODATA      = 2'd2,
    REG_THRESHOLD   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TW_W-1:0]          tile_width;
    logic [TH_W-1:0]          tile_height;
    logic signed [ELEV_W-1:0] nodata_value;
    logic [THR_W-1:0]         spike_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [ELEV_W-1:0] clean_elevation;
    logic                     was_removed;
    logic                     last_of_tile;
  } result_t;

endpackage

`default_nettype wire

/* rtl/esr_if.sv */
// Valid/ready channel interfaces for samples in and results out.
`default_nettype none

interface esr_in_if import esr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [ELEV_W-1:0] elevation;

  modport source (output valid, output req_type, output elevation, input ready);
  modport sink   (input valid, input req_type, input elevation, output ready);
endinterface

interface esr_out_if import esr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEV_W-1:0] clean_elevation;
  logic                     was_removed;
  logic                     last_of_tile;

  modport source (output valid, output clean_elevation, output was_removed,
                  output last_of_tile, input ready);
  modport sink   (input valid, input clean_elevation, input was_removed,
                  input last_of_tile, output ready);
endinterface

`default_nettype wire

/* rtl/elevation_spike_remover.sv */
// Elevation spike remover: streaming 4-neighbour spike filter over raster tiles.
// Latency: a sample's result is pushed when the sample below it (one row of input
//   transfers later, or the matching flush tick) is accepted, and shows at the output
//   in the next cycle unless older ones wait. Throughput: one input transfer per cycle,
//   set by the line buffer read ports; ready drops while both result buffer entries are
//   full and for one cycle after each register write. Reset: synchronous, clears counters
//   and buffer state; line buffers are undefined until written and get no clearing pass.
`default_nettype none

module elevation_spike_remover import esr_pkg::*; #(
  parameter int MAX_TILE_WIDTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  esr_in_if.sink            sample_in,
  esr_out_if.source         result_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CW = $clog2(MAX_TILE_WIDTH);  // column index bits
  localparam int WW = CW + 1;                  // holds the width itself

  // ---------------------------------------------------------------- config
  cfg_t cfg;
  logic cfg_wr;
  logic cfg_hold;   // line buffer prefetch refreshes for one cycle after a write

  esr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  // ---------------------------------------------------------------- state
  logic [CW-1:0]     column_count, column_next;
  logic [TH_W-1:0]   row_count, row_next;
  logic [ELEV_W-1:0] cleaned_left;

  // Effective tile size: width zero acts as one and saturates at the buffer depth,
  // height zero acts as one.
  logic [WW-1:0]   w_eff;
  logic [TH_W-1:0] h_eff;
  logic [TH_W-1:0] row_c;
  logic [CW-1:0]   x;        // column of this transfer, clamped to the width
  logic [CW-1:0]   xn;       // column of the next transfer, clamped
  logic [CW-1:0]   xn_p1;
  logic            x_last;
  logic            flush;
  logic            filled;

  always_comb begin
    if (cfg.tile_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg.tile_width) > MAX_TILE_WIDTH) begin
      w_eff = WW'(MAX_TILE_WIDTH);
    end else begin
      w_eff = WW'(cfg.tile_width);
    end
    h_eff = (cfg.tile_height == '0) ? TH_W'(1) : cfg.tile_height;
    row_c = (row_count > h_eff) ? h_eff : row_count;
    x     = ({1'b0, column_count} >= w_eff) ? CW'(w_eff - WW'(1)) : column_count;
  end

  assign x_last = (WW'(x) + WW'(1)) >= w_eff;
  assign flush  = (row_c == h_eff);     // all rows in: only the held row drains
  assign filled = (row_c != '0);        // a row is held back, so results flow

  // ---------------------------------------------------------------- handshake
  logic buf_full;
  logic in_xfer;
  logic step;       // transfer that advances the scan (early flush ticks do not)
  logic produce;
  logic              removed;
  logic signed [ELEV_W-1:0] clean;

  assign sample_in.ready = !buf_full && !cfg_hold;
  assign in_xfer = sample_in.valid && sample_in.ready;
  assign step    = in_xfer && (flush || sample_in.req_type == REQ_SAMPLE);
  assign produce = step && filled;

  always_comb begin
    column_next = column_count;
    row_next    = row_count;
    if (step) begin
      if (x_last) begin
        column_next = '0;
        row_next    = flush ? '0 : row_c + TH_W'(1);
      end else begin
        column_next = x + CW'(1);
        row_next    = row_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      cleaned_left <= '0;
      cfg_hold     <= 1'b0;
    end else begin
      column_count <= column_next;
      row_count    <= row_next;
      cfg_hold     <= cfg_wr;
      if (produce) begin
        cleaned_left <= clean;
      end
    end
  end

  // ---------------------------------------------------------------- line buffers
  // The RAMs are always read at the addresses the next transfer needs, taken from
  // the next-state column, so the registered read data is ready whenever a sample
  // turns up. pending_row has two copies for the centre and right-hand reads.
  // A write to the address being prefetched in the same cycle is forwarded.
  logic              pend_we;
  logic              clean_we;
  logic [ELEV_W-1:0] ram_centre, ram_right, ram_above;
  logic              hit_centre, hit_right, hit_above;
  logic [ELEV_W-1:0] byp_raw, byp_clean;
  logic signed [ELEV_W-1:0] centre, right_nb, above_nb;

  assign xn    = ({1'b0, column_next} >= w_eff) ? CW'(w_eff - WW'(1)) : column_next;
  assign xn_p1 = xn + CW'(1);

  assign pend_we  = step && !flush;
  assign clean_we = produce;

  esr_ram #(.WIDTH(ELEV_W), .DEPTH(MAX_TILE_WIDTH)) u_pend_centre (
    .clk   (clk),
    .we    (pend_we),
    .waddr (x),
    .wdata (sample_in.elevation),
    .raddr (xn),
    .rdata (ram_centre)
  );

  esr_ram #(.WIDTH(ELEV_W), .DEPTH(MAX_TILE_WIDTH)) u_pend_right (
    .clk   (clk),
    .we    (pend_we),
    .waddr (x),
    .wdata (sample_in.elevation),
    .raddr (xn_p1),
    .rdata (ram_right)
  );

  esr_ram #(.WIDTH(ELEV_W), .DEPTH(MAX_TILE_WIDTH)) u_row_above (
    .clk   (clk),
    .we    (clean_we),
    .waddr (x),
    .wdata (clean),
    .raddr (xn),
    .rdata (ram_above)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_centre <= 1'b0;
      hit_right  <= 1'b0;
      hit_above  <= 1'b0;
    end else begin
      hit_centre <= pend_we  && (x == xn);
      hit_right  <= pend_we  && (x == xn_p1);
      hit_above  <= clean_we && (x == xn);
    end
  end

  always_ff @(posedge clk) begin
    byp_raw   <= sample_in.elevation;
    byp_clean <= clean;
  end

  assign centre   = hit_centre ? byp_raw   : ram_centre;
  assign right_nb = hit_right  ? byp_raw   : ram_right;
  assign above_nb = hit_above  ? byp_clean : ram_above;

  // ---------------------------------------------------------------- compare
  // Right and lower neighbours raw, left and upper already cleaned.
  esr_spike_check u_check (
    .centre          (centre),
    .right_nb        (right_nb),
    .below_nb        (sample_in.elevation),
    .left_nb         (cleaned_left),
    .above_nb        (above_nb),
    .use_right       (!x_last),
    .use_below       (!flush),
    .use_left        (x != '0),
    .use_above       (row_c >= TH_W'(2)),
    .nodata_value    (cfg.nodata_value),
    .spike_threshold (cfg.spike_threshold),
    .removed         (removed),
    .clean           (clean)
  );

  // ---------------------------------------------------------------- results
  result_t res_in;
  result_t res_out;
  logic    res_valid;

  assign res_in.clean_elevation = clean;
  assign res_in.was_removed     = removed;
  assign res_in.last_of_tile    = flush && x_last;

  esr_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (produce),
    .push_data (res_in),
    .pop       (res_valid && result_out.ready),
    .full      (buf_full),
    .out_valid (res_valid),
    .out_data  (res_out)
  );

  assign result_out.valid           = res_valid;
  assign result_out.clean_elevation = res_out.clean_elevation;
  assign result_out.was_removed     = res_out.was_removed;
  assign result_out.last_of_tile    = res_out.last_of_tile;

endmodule

`default_nettype wire

/* rtl/esr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module esr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/esr_cfg_regs.sv */
// APB configuration registers.
`default_nettype none

module esr_cfg_regs import esr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              cfg_wr
);

  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_width      <= TILE_WIDTH_RST;
      cfg.tile_height     <= TILE_HEIGHT_RST;
      cfg.nodata_value    <= NODATA_RST;
      cfg.spike_threshold <= THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (idx)
        REG_TILE_WIDTH:  cfg.tile_width      <= pwdata[TW_W-1:0];
        REG_TILE_HEIGHT: cfg.tile_height     <= pwdata[TH_W-1:0];
        REG_NODATA:      cfg.nodata_value    <= pwdata[ELEV_W-1:0];
        REG_THRESHOLD:   cfg.spike_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TILE_WIDTH:  prdata = APB_DW'(cfg.tile_width);
      REG_TILE_HEIGHT: prdata = APB_DW'(cfg.tile_height);
      REG_NODATA:      prdata = APB_DW'(unsigned'(cfg.nodata_value));
      REG_THRESHOLD:   prdata = APB_DW'(cfg.spike_threshold);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/esr_spike_check.sv */
// Neighbour compares and nodata substitution for one sample.
`default_nettype none

module esr_spike_check import esr_pkg::*; (
  input  logic signed [ELEV_W-1:0] centre,
  input  logic signed [ELEV_W-1:0] right_nb,
  input  logic signed [ELEV_W-1:0] below_nb,
  input  logic signed [ELEV_W-1:0] left_nb,
  input  logic signed [ELEV_W-1:0] above_nb,
  input  logic                     use_right,
  input  logic                     use_below,
  input  logic                     use_left,
  input  logic                     use_above,
  input  logic signed [ELEV_W-1:0] nodata_value,
  input  logic [THR_W-1:0]         spike_threshold,
  output logic                     removed,
  output logic signed [ELEV_W-1:0] clean
);

  // exact rise, two extra bits so nothing wraps
  function automatic logic spike(input logic signed [ELEV_W-1:0] e,
                                 input logic signed [ELEV_W-1:0] nb,
                                 input logic signed [ELEV_W-1:0] nd,
                                 input logic [THR_W-1:0] thr);
    logic signed [ELEV_W+1:0] rise;
    rise = (ELEV_W+2)'(e) - (ELEV_W+2)'(nb);
    return (nb != nd) && (rise > $signed({2'b00, thr}));
  endfunction

  always_comb begin
    removed = 1'b0;
    if (centre != nodata_value) begin
      removed = (use_right && spike(centre, right_nb, nodata_value, spike_threshold)) ||
                (use_below && spike(centre, below_nb, nodata_value, spike_threshold)) ||
                (use_left  && spike(centre, left_nb,  nodata_value, spike_threshold)) ||
                (use_above && spike(centre, above_nb, nodata_value, spike_threshold));
    end
    clean = removed ? nodata_value : centre;
  end

endmodule

`default_nettype wire

/* rtl/esr_out_buf.sv */
// Two-entry result buffer between the datapath and the output channel.
`default_nettype none

module esr_out_buf import esr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    full,
  output logic    out_valid,
  output result_t out_data
);

  result_t    ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/esr_checker.sv */
// Port-level assertions for the spike remover, bound to the top level.
`default_nettype none

module esr_checker import esr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ELEV_W-1:0] out_clean,
  input logic              out_removed,
  input logic              out_last,
  input logic              psel,
  input logic              penable,
  input logic              pwrite
);

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_clean) &&
                                $stable(out_removed) && $stable(out_last))
    else $error("result changed while stalled");

  // input pauses for one cycle after a register write
  a_cfg_pause: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> !in_ready)
    else $error("input accepted straight after a register write");

  // nothing left in the result buffer after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // the input only back-pressures when results are waiting or after a write
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready && !$past(cfg_wr) |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind elevation_spike_remover esr_checker u_esr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (sample_in.ready),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .out_clean   (result_out.clean_elevation),
  .out_removed (result_out.was_removed),
  .out_last    (result_out.last_of_tile),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite)
);

`default_nettype wire
